@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bhpq_pkg.sv @@
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  // fixed field widths on the ports
  localparam int KEY_FIELD_W   = 32;
  localparam int COUNT_FIELD_W = 11;
  localparam int STATUS_W      = 2;
  localparam int OUT_TDATA_W   = 80;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_LAST,
    S_DN_RDR,
    S_DN_SEL,
    S_DN_MOV,
    S_PLACE,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bhpq_ram.sv @@
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/binary_heap_priority_queue.sv @@
// Binary heap priority queue of up to DEPTH keys held in a single-port-read RAM.
// A transfer on s_* is a push of a key (tuser 0) or a pop of the top entry (tuser 1);
// each gives exactly one result transfer on m_*, with the status, the popped key,
// the new top and the entry count. max_order (cfg_data) picks a min-heap (0) or a
// max-heap (1); it must be written only while the queue is idle, which the block
// itself does not enforce. One operation runs at a time. A push moves its key up
// level by level and a pop moves the last entry down from the root. The result is
// offered as the input opens again, and a result not yet taken holds the next
// operation back while the current one waits in its final state. The pace is set
// by the RAM's one registered read port and the single comparator that every level
// goes through. Errors (push when full, pop when empty) change nothing.
`default_nettype none

module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_data,   // max_order
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [KEY_FIELD_W-1:0] s_tdata,    // key
  input  wire logic                   s_tuser,    // opcode
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // popped_key[31:0], top_key[63:32], top_valid[64], entry_count[75:65], zero[79:76]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic [STATUS_W-1:0]         m_tuser     // status
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CHW = AW + 2;

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        par;
  logic [AW-1:0]        cidx;
  logic [KEY_WIDTH-1:0] key_hold;
  logic [KEY_WIDTH-1:0] left_key;
  logic                 have_right;
  status_t              status_r;
  logic [KEY_WIDTH-1:0] popped_r;
  logic [KEY_WIDTH-1:0] root_key;
  logic                 max_order;

  logic [STATUS_W-1:0]      o_status;
  logic [KEY_FIELD_W-1:0]   o_popped;
  logic [KEY_FIELD_W-1:0]   o_top;
  logic                     o_top_valid;
  logic [COUNT_FIELD_W-1:0] o_count;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [KEY_WIDTH-1:0] wr_data, rd_data;

  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_sink;

  logic [CW-1:0]        cnt_m1, cnt_half;
  logic [AW-1:0]        par_of_cnt, par_up;
  logic [CHW-1:0]       child_w, other_w, next_child, count_x;
  logic [63:0]          key_in_ext, popped_ext, root_ext;
  logic [KEY_WIDTH-1:0] key_in;
  logic [31:0]          count_ext;
  logic                 s_xfer, fin_go, is_full, is_empty;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign fin_go    = (state == S_FIN) && (!m_tvalid || m_tready);
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);

  assign key_in_ext = {32'b0, s_tdata};
  assign key_in     = key_in_ext[KEY_WIDTH-1:0];
  assign popped_ext = 64'(popped_r);
  assign root_ext   = 64'(root_key);
  assign count_ext  = 32'(count);

  assign cnt_m1     = count - CW'(1);
  assign cnt_half   = cnt_m1 >> 1;
  assign par_of_cnt = cnt_half[AW-1:0];
  assign par_up     = (par - AW'(1)) >> 1;
  assign child_w    = (CHW'(idx) << 1) + CHW'(1);
  assign other_w    = child_w + CHW'(1);
  assign next_child = (CHW'(cidx) << 1) + CHW'(1);
  assign count_x    = CHW'(count);

  // the one shared comparator: true when a belongs below b
  assign cmp_sink = max_order ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  bhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = key_hold;
    cmp_a      = rd_data;
    cmp_b      = key_hold;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_PUSH) begin
            if (is_full) begin
              state_next = S_FIN;
            end else if (is_empty) begin
              state_next = S_PLACE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = par_of_cnt;
              state_next = S_UP;
            end
          end else begin
            if (is_empty) begin
              state_next = S_FIN;
            end else begin
              // fetch the last entry
              rd_en      = 1'b1;
              rd_addr    = cnt_m1[AW-1:0];
              state_next = S_DN_LAST;
            end
          end
        end
      end
      S_UP: begin
        if (cmp_sink) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          if (par == '0) begin
            state_next = S_PLACE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = par_up;
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_LAST: begin
        if (CHW'(1) < count_x) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(1);
          state_next = S_DN_RDR;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_RDR: begin
        if (other_w < count_x) begin
          rd_en   = 1'b1;
          rd_addr = other_w[AW-1:0];
        end
        state_next = S_DN_SEL;
      end
      S_DN_SEL: begin
        cmp_a      = left_key;
        cmp_b      = rd_data;
        state_next = S_DN_MOV;
      end
      S_DN_MOV: begin
        cmp_a = key_hold;
        cmp_b = left_key;
        if (cmp_sink) begin
          wr_en   = 1'b1;
          wr_data = left_key;
          if (next_child < count_x) begin
            rd_en      = 1'b1;
            rd_addr    = next_child[AW-1:0];
            state_next = S_DN_RDR;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_PUSH) begin
            popped_r <= '0;
            if (is_full) begin
              status_r <= ST_FULL;
            end else begin
              status_r <= ST_DONE;
              key_hold <= key_in;
              idx      <= count[AW-1:0];
              par      <= par_of_cnt;
            end
          end else begin
            if (is_empty) begin
              status_r <= ST_EMPTY;
              popped_r <= '0;
            end else begin
              status_r <= ST_DONE;
              popped_r <= root_key;
              idx      <= '0;
            end
          end
        end
      end
      S_UP: begin
        if (cmp_sink) begin
          idx <= par;
          par <= par_up;
        end
      end
      S_DN_LAST: begin
        key_hold <= rd_data;
      end
      S_DN_RDR: begin
        left_key   <= rd_data;
        cidx       <= child_w[AW-1:0];
        have_right <= (other_w < count_x);
      end
      S_DN_SEL: begin
        if (have_right && cmp_sink) begin
          left_key <= rd_data;
          cidx     <= other_w[AW-1:0];
        end
      end
      S_DN_MOV: begin
        if (cmp_sink) begin
          idx <= cidx;
        end
      end
      default: ;
    endcase
    // keep a copy of the root so the top needs no read
    if (wr_en && (wr_addr == '0)) begin
      root_key <= wr_data;
    end
    if (fin_go) begin
      o_status    <= status_r;
      o_popped    <= popped_ext[KEY_FIELD_W-1:0];
      o_top       <= is_empty ? '0 : root_ext[KEY_FIELD_W-1:0];
      o_top_valid <= !is_empty;
      o_count     <= count_ext[COUNT_FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      max_order <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_order <= cfg_data;
      end
      if (s_xfer) begin
        if ((s_tuser == OP_PUSH) && !is_full) begin
          count <= count + CW'(1);
        end else if ((s_tuser == OP_POP) && !is_empty) begin
          count <= cnt_m1;
        end
      end
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {4'b0, o_count, o_top_valid, o_top, o_popped};
  assign m_tuser = o_status;

endmodule

`default_nettype wire

@@ rtl/bhpq_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module bhpq_protocol_checker
  import bhpq_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [STATUS_W-1:0]    m_tuser
);

  // a stalled result holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

  // one operation at a time: the input closes after every transfer
  `ASSERT_CLK_RST(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "input still open after a transfer")

  // a pop on an empty queue reports an empty queue and nothing popped
  `ASSERT_CLK_RST(a_empty_pop, clk, rst, (m_tvalid && (m_tuser == ST_EMPTY)) |-> ((m_tdata[31:0] == 32'd0) && !m_tdata[64] && (m_tdata[75:65] == 11'd0)), "empty pop result not clean")

  // no top reported without a valid top
  `ASSERT_CLK_RST(a_top_zero, clk, rst, (m_tvalid && !m_tdata[64]) |-> (m_tdata[63:32] == 32'd0), "top key set while queue empty")

endmodule

bind binary_heap_priority_queue bhpq_protocol_checker u_bhpq_protocol_checker (.*);

`default_nettype wire
